### hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, codes and types of the bitmap block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int GROUPS          = 8;
    localparam int BITS_PER_GROUP  = 8192;
    localparam int WORD_BITS       = 32;
    localparam int WORDS_PER_GROUP = BITS_PER_GROUP / WORD_BITS;
    localparam int TOTAL_WORDS     = GROUPS * WORDS_PER_GROUP;

    localparam int GRP_W  = 3;
    localparam int ITEM_W = 17;
    localparam int CNT_W  = 14;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int WIDX_W = $clog2(WORDS_PER_GROUP);
    localparam int ADDR_W = $clog2(TOTAL_WORDS);
    localparam int OFFS_W = $clog2(BITS_PER_GROUP);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_FCHK,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

### hdl/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if
// request and response channels of the bitmap block allocator
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if import bba_pkg::*; ;
    logic              valid;
    logic              ready;
    t_cmd              cmd;
    logic [GRP_W-1:0]  group;
    logic [ITEM_W-1:0] item_number;

    modport source (output valid, cmd, group, item_number, input ready);
    modport sink   (input valid, cmd, group, item_number, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [ITEM_W-1:0] result_item;
    t_status           status;
    logic [CNT_W-1:0]  group_free;

    modport source (output valid, result_item, status, group_free, input ready);
    modport sink   (input valid, result_item, status, group_free, output ready);
endinterface

`default_nettype wire

### hdl/bitmap_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// first-fit bitmap allocator with one bitmap and one used count per group
//
//   channel  dir  handshake            payload
//   i_req    in   valid/ready          cmd, group, item_number
//   o_rsp    out  valid/ready          result_item, status, group_free
//   apb      in   psel/penable/pwrite  paddr, pwdata, prdata (items_per_group)
//
// alloc: (n+31)/32 words scanned at most, one word per cycle through the
//   bitmap memory read port; the scan stops at the first word with a free
//   bit, or after the last word of a full group
// free: repeated subtraction for the group, then the bit is checked and, if set, cleared
// after reset a clearing pass writes all 2048 bitmap words
// a stalled result sits in the output register while the next item runs
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_unit import bba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bba_req_if.sink          i_req,
    bba_rsp_if.source        o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    function automatic logic [BIT_W-1:0] f_lowest(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [WORD_BITS-1:0] r_mem [TOTAL_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_ipg, n_ipg;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [CNT_W-1:0]    r_cnt [GROUPS];
    logic [CNT_W-1:0]    n_cnt [GROUPS];
    logic                r_out_valid, n_out_valid;
    logic [ITEM_W-1:0]   r_out_item, n_out_item;
    t_status             r_out_status, n_out_status;
    logic [CNT_W-1:0]    r_out_gfree, n_out_gfree;
    logic [GRP_W-1:0]    r_g, n_g;
    logic [ITEM_W-1:0]   r_base, n_base;
    logic [WIDX_W-1:0]   r_widx, n_widx;
    logic [WIDX_W-1:0]   r_cidx, n_cidx;
    logic                r_cvalid, n_cvalid;
    logic [ITEM_W-1:0]   r_rem, n_rem;
    logic [ITEM_W-1:0]   r_res_item, n_res_item;
    t_status             r_res_status, n_res_status;

    logic                 w_accept;
    logic                 w_cfg_wr;
    logic [CNT_W-1:0]     w_n;
    logic [CNT_W-1:0]     w_nm1;
    logic [WIDX_W-1:0]    w_last;
    logic [WORD_BITS-1:0] w_vmask;
    logic [WORD_BITS-1:0] w_avail;
    logic                 w_found;
    logic [BIT_W-1:0]     w_fbit;
    logic                 w_scan_end;
    logic                 w_rem_lt;
    logic                 w_bit_set;
    logic [CNT_W-1:0]     w_cnt_g;
    logic [CNT_W-1:0]     w_gfree;
    logic                 w_out_free;

    logic                 w_mem_re;
    logic [ADDR_W-1:0]    w_mem_raddr;
    logic                 w_mem_we;
    logic [ADDR_W-1:0]    w_mem_waddr;
    logic [WORD_BITS-1:0] w_mem_wdata;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata   = (paddr == 3'd0) ? 32'(r_ipg) : '0;

    assign w_n   = (r_ipg > CNT_W'(BITS_PER_GROUP)) ? CNT_W'(BITS_PER_GROUP) : r_ipg;
    assign w_nm1 = w_n - CNT_W'(1);
    assign w_last = w_nm1[BIT_W +: WIDX_W];

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // scan of one bitmap word
    assign w_vmask = (r_cidx == w_last)
                   ? ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - w_nm1[BIT_W-1:0]))
                   : {WORD_BITS{1'b1}};
    assign w_avail    = ~r_rdata & w_vmask;
    assign w_found    = r_cvalid && (w_avail != '0);
    assign w_fbit     = f_lowest(w_avail);
    assign w_scan_end = r_cvalid && (r_cidx == w_last);

    assign w_rem_lt  = r_rem < ITEM_W'(w_n);
    assign w_bit_set = r_rdata[r_rem[BIT_W-1:0]];

    assign w_cnt_g = r_cnt[r_g];
    assign w_gfree = (w_cnt_g >= w_n) ? '0 : (w_n - w_cnt_g);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_W'(TOTAL_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.cmd == CMD_ALLOC) begin
                        n_state = (w_n == '0) ? S_RESP : S_SCAN;
                    end else begin
                        n_state = (i_req.item_number == '0 || w_n == '0) ? S_RESP : S_DIV;
                    end
                end
            end
            S_SCAN: begin
                if (w_found || w_scan_end) n_state = S_RESP;
            end
            S_DIV: begin
                if (w_rem_lt) n_state = S_FCHK;
                else if (r_g == GRP_W'(GROUPS - 1)) n_state = S_RESP;
            end
            S_FCHK: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // outputs and memory control
    always_comb begin
        i_req.ready = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_raddr = {r_g, r_widx};
        w_mem_we    = 1'b0;
        w_mem_waddr = {r_g, r_cidx};
        w_mem_wdata = r_rdata | (WORD_BITS'(1) << w_fbit);
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr;
                w_mem_wdata = '0;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_SCAN: begin
                w_mem_we = w_found;
                w_mem_re = !w_found && !w_scan_end;
            end
            S_DIV: begin
                w_mem_re    = w_rem_lt;
                w_mem_raddr = {r_g, r_rem[BIT_W +: WIDX_W]};
            end
            S_FCHK: begin
                w_mem_we    = w_bit_set;
                w_mem_waddr = {r_g, r_rem[BIT_W +: WIDX_W]};
                w_mem_wdata = r_rdata & ~(WORD_BITS'(1) << r_rem[BIT_W-1:0]);
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        n_ipg        = w_cfg_wr ? pwdata[CNT_W-1:0] : r_ipg;
        n_clr        = r_clr;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_item   = r_out_item;
        n_out_status = r_out_status;
        n_out_gfree  = r_out_gfree;
        n_g          = r_g;
        n_base       = r_base;
        n_widx       = r_widx;
        n_cidx       = r_cidx;
        n_cvalid     = r_cvalid;
        n_rem        = r_rem;
        n_res_item   = r_res_item;
        n_res_status = r_res_status;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
            end
            S_IDLE: begin
                n_res_item = '0;
                n_widx     = '0;
                n_cvalid   = 1'b0;
                n_g        = (i_req.cmd == CMD_ALLOC) ? i_req.group : '0;
                n_base     = ITEM_W'(i_req.group) * ITEM_W'(w_n);
                n_rem      = i_req.item_number - ITEM_W'(1);
                if (i_req.cmd == CMD_ALLOC) n_res_status = ST_FULL;
                else                        n_res_status = ST_RANGE;
            end
            S_SCAN: begin
                if (w_found) begin
                    n_res_status = ST_OK;
                    n_res_item   = r_base + ITEM_W'({r_cidx, w_fbit}) + ITEM_W'(1);
                    if (w_cnt_g != CNT_MAX) n_cnt[r_g] = w_cnt_g + CNT_W'(1);
                end else if (!w_scan_end) begin
                    n_widx   = r_widx + WIDX_W'(1);
                    n_cidx   = r_widx;
                    n_cvalid = 1'b1;
                end
            end
            S_DIV: begin
                if (!w_rem_lt) begin
                    n_rem = r_rem - ITEM_W'(w_n);
                    n_g   = r_g + GRP_W'(1);
                end
            end
            S_FCHK: begin
                if (w_bit_set) begin
                    n_res_status = ST_OK;
                    if (w_cnt_g != '0) n_cnt[r_g] = w_cnt_g - CNT_W'(1);
                end else begin
                    n_res_status = ST_ALREADY_FREE;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_item   = r_res_item;
                    n_out_status = r_res_status;
                    n_out_gfree  = (r_res_status == ST_RANGE) ? '0 : w_gfree;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ipg       <= CNT_W'(BITS_PER_GROUP);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < GROUPS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ipg       <= n_ipg;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item   <= n_out_item;
        r_out_status <= n_out_status;
        r_out_gfree  <= n_out_gfree;
        r_g          <= n_g;
        r_base       <= n_base;
        r_widx       <= n_widx;
        r_cidx       <= n_cidx;
        r_cvalid     <= n_cvalid;
        r_rem        <= n_rem;
        r_res_item   <= n_res_item;
        r_res_status <= n_res_status;
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_waddr] <= w_mem_wdata;
        if (w_mem_re) r_rdata <= r_mem[w_mem_raddr];
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_item = r_out_item;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.group_free  = r_out_gfree;

endmodule

`default_nettype wire

### hdl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the bitmap block allocator
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker import bba_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              o_rsp_valid,
    input wire logic              o_rsp_ready,
    input wire logic [ITEM_W-1:0] o_rsp_result_item,
    input wire logic [1:0]        o_rsp_status,
    input wire logic [CNT_W-1:0]  o_rsp_group_free
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_result_item)
            && $stable(o_rsp_status) && $stable(o_rsp_group_free))
        else $error("stalled response changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    a_rsp_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(!i_req_ready))
        else $error("response without a request in work");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request ready during clearing pass");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_status == ST_RANGE |->
            o_rsp_result_item == '0 && o_rsp_group_free == '0)
        else $error("out of range response carries data");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .o_rsp_valid       (o_rsp.valid),
    .o_rsp_ready       (o_rsp.ready),
    .o_rsp_result_item (o_rsp.result_item),
    .o_rsp_status      (o_rsp.status),
    .o_rsp_group_free  (o_rsp.group_free)
);

`default_nettype wire
